>>> hw/rtl/char_lcd_4bit_sequencer_assert.svh
// Assertion macros used by the RTL that checks itself.
`ifndef CHAR_LCD_4BIT_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_4BIT_SEQUENCER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CLCD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("clcd assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CLCD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("clcd assertion failed");

`endif

>>> hw/rtl/clcd_pkg.sv
`default_nettype none

package clcd_pkg;

  // Request codes on the op field
  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_CMD    = 3'd1;
  localparam logic [2:0] OP_DATA   = 3'd2;
  localparam logic [2:0] OP_CURSOR = 3'd3;
  localparam logic [2:0] OP_INIT   = 3'd4;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_ENABLE_WIDTH   = 3'd0;
  localparam logic [2:0] REG_NIBBLE_GAP     = 3'd1;
  localparam logic [2:0] REG_COMMAND_GAP    = 3'd2;
  localparam logic [2:0] REG_LONG_CMD_WAIT  = 3'd3;
  localparam logic [2:0] REG_POWERUP_WAIT   = 3'd4;
  localparam logic [2:0] REG_INIT_STEP_WAIT = 3'd5;

  localparam int unsigned AddrW = 5;
  localparam int unsigned WaitW = 17;

  localparam logic [7:0] LINE0_BASE = 8'h80;
  localparam logic [7:0] LINE1_BASE = 8'hC0;
  localparam logic [7:0] CMD_CLEAR  = 8'h01;
  localparam logic [7:0] CMD_HOME   = 8'h02;
  localparam logic [3:0] NIB_WAKE   = 4'h3;
  localparam logic [3:0] NIB_4BIT   = 4'h2;
  localparam logic [3:0] NIB_MASK   = 4'hF;

  typedef struct packed {
    logic [15:0]      enable_width;
    logic [15:0]      nibble_gap;
    logic [15:0]      command_gap;
    logic [WaitW-1:0] long_command_wait;
    logic [WaitW-1:0] powerup_wait;
    logic [WaitW-1:0] init_step_wait;
  } cfg_t;

  // A zero duration counts as one tick
  function automatic logic [WaitW-1:0] dur(input logic [WaitW-1:0] v);
    dur = (v == '0) ? WaitW'(1) : v;
  endfunction

  // Commands sent after the wake-up nibbles, init step 5 to 9
  function automatic logic [7:0] init_cmd(input logic [3:0] idx);
    case (idx)
      4'd5:    init_cmd = 8'h28;
      4'd6:    init_cmd = 8'h0C;
      4'd7:    init_cmd = 8'h06;
      4'd8:    init_cmd = CMD_CLEAR;
      4'd9:    init_cmd = LINE0_BASE;
      default: init_cmd = 8'h00;
    endcase
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/clcd_req_if.sv
`default_nettype none

interface clcd_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [7:0] value;
  logic [1:0] row;
  logic [5:0] col;

  modport source (output valid, op, value, row, col, input ready);
  modport sink (input valid, op, value, row, col, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/clcd_pin_if.sv
`default_nettype none

interface clcd_pin_if;
  logic       valid;
  logic       ready;
  logic       rs;
  logic       en;
  logic [3:0] nibble;
  logic       busy_res;
  logic       rejected;

  modport source (output valid, rs, en, nibble, busy_res, rejected, input ready);
  modport sink (input valid, rs, en, nibble, busy_res, rejected, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/char_lcd_4bit_sequencer.sv
// The result of an input transfer is registered in the output register.
// Throughput: one item per cycle; the sequencer state and the output register
// update in the same cycle, so a new item is taken whenever the output is free
// or being drained.
// Reset: sequencer idle, counters and pins cleared, timing registers at defaults.
`default_nettype none

module char_lcd_4bit_sequencer (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  clcd_req_if.sink                        in_i,
  clcd_pin_if.source                      out_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [clcd_pkg::AddrW-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready
);

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_PWRUP = 3'd1;
  localparam logic [2:0] PH_EN    = 3'd2;
  localparam logic [2:0] PH_NGAP  = 3'd3;
  localparam logic [2:0] PH_BGAP  = 3'd4;
  localparam logic [2:0] PH_IGAP  = 3'd5;

  localparam int unsigned WaitW = clcd_pkg::WaitW;

  clcd_pkg::cfg_t cfg;

  logic [2:0]       phase_q, phase_d;
  logic [WaitW-1:0] wait_q, wait_d;
  logic [7:0]       byte_q, byte_d;
  logic             rs_q, rs_d;
  logic [3:0]       idx_q, idx_d;
  logic             low_q, low_d;
  logic [5:0]       pins_q, pins_d;
  logic [5:0]       shown;
  logic             is_req;
  logic             rej;
  logic             acc;
  logic             out_valid_q;

  clcd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign acc    = in_i.valid && in_i.ready;
  assign is_req = (in_i.op == clcd_pkg::OP_CMD) || (in_i.op == clcd_pkg::OP_DATA) ||
                  (in_i.op == clcd_pkg::OP_CURSOR) || (in_i.op == clcd_pkg::OP_INIT);
  assign in_i.ready = !out_valid_q || out_o.ready;

  always_comb begin
    phase_d = phase_q;
    wait_d  = wait_q;
    byte_d  = byte_q;
    rs_d    = rs_q;
    idx_d   = idx_q;
    low_d   = low_q;
    pins_d  = pins_q;
    rej     = 1'b0;

    // Start a new sequence when idle (the request also counts as its first tick); a request while busy is rejected
    if (phase_q == PH_IDLE) begin
      if (is_req) begin
        idx_d = 4'd0;
        if (in_i.op == clcd_pkg::OP_INIT) begin
          pins_d  = {2'b00, pins_q[3:0]};
          phase_d = PH_PWRUP;
          wait_d  = clcd_pkg::dur(cfg.powerup_wait);
        end else begin
          case (in_i.op)
            clcd_pkg::OP_CMD: begin
              byte_d = in_i.value;
              rs_d   = 1'b0;
            end
            clcd_pkg::OP_DATA: begin
              byte_d = in_i.value;
              rs_d   = 1'b1;
            end
            default: begin
              byte_d = ((in_i.row == 2'd1) ? clcd_pkg::LINE1_BASE : clcd_pkg::LINE0_BASE)
                       + {2'b00, in_i.col};
              rs_d   = 1'b0;
            end
          endcase
          low_d   = 1'b0;
          pins_d  = {rs_d, 1'b1, byte_d[7:4]};
          phase_d = PH_EN;
          wait_d  = clcd_pkg::dur({1'b0, cfg.enable_width});
        end
      end
    end else if (is_req) begin
      rej = 1'b1;
    end

    shown = pins_d;

    if (phase_d != PH_IDLE) begin
      wait_d = wait_d - WaitW'(1);
      if (wait_d == '0) begin
        case (phase_d)
          PH_PWRUP: begin
            idx_d   = 4'd1;
            pins_d  = {2'b01, clcd_pkg::NIB_WAKE};
            phase_d = PH_EN;
            wait_d  = clcd_pkg::dur({1'b0, cfg.enable_width});
          end
          PH_EN: begin
            pins_d[4] = 1'b0;
            phase_d   = PH_NGAP;
            wait_d    = clcd_pkg::dur({1'b0, cfg.nibble_gap});
          end
          PH_NGAP: begin
            if (idx_d >= 4'd1 && idx_d <= 4'd4) begin
              phase_d = PH_IGAP;
              wait_d  = clcd_pkg::dur(cfg.init_step_wait);
            end else if (!low_d) begin
              low_d   = 1'b1;
              pins_d  = {rs_d, 1'b1, byte_d[3:0] & clcd_pkg::NIB_MASK};
              phase_d = PH_EN;
              wait_d  = clcd_pkg::dur({1'b0, cfg.enable_width});
            end else begin
              phase_d = PH_BGAP;
              // Clear and home need the long settle time
              if (!rs_d && (byte_d == clcd_pkg::CMD_CLEAR || byte_d == clcd_pkg::CMD_HOME)) begin
                wait_d = clcd_pkg::dur(cfg.long_command_wait);
              end else begin
                wait_d = clcd_pkg::dur({1'b0, cfg.command_gap});
              end
            end
          end
          PH_BGAP: begin
            if (idx_d != 4'd0) begin
              phase_d = PH_IGAP;
              wait_d  = clcd_pkg::dur(cfg.init_step_wait);
            end else begin
              phase_d = PH_IDLE;
              wait_d  = '0;
            end
          end
          PH_IGAP: begin
            idx_d = idx_d + 4'd1;
            if (idx_d >= 4'd1 && idx_d <= 4'd4) begin
              pins_d  = {2'b01, (idx_d < 4'd4) ? clcd_pkg::NIB_WAKE : clcd_pkg::NIB_4BIT};
              phase_d = PH_EN;
              wait_d  = clcd_pkg::dur({1'b0, cfg.enable_width});
            end else if (idx_d >= 4'd5 && idx_d <= 4'd9) begin
              byte_d  = clcd_pkg::init_cmd(idx_d);
              rs_d    = 1'b0;
              low_d   = 1'b0;
              pins_d  = {1'b0, 1'b1, byte_d[7:4]};
              phase_d = PH_EN;
              wait_d  = clcd_pkg::dur({1'b0, cfg.enable_width});
            end else begin
              idx_d   = 4'd0;
              phase_d = PH_IDLE;
              wait_d  = '0;
            end
          end
          default: begin
            phase_d = PH_IDLE;
            wait_d  = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      wait_q  <= '0;
      byte_q  <= '0;
      rs_q    <= 1'b0;
      idx_q   <= '0;
      low_q   <= 1'b0;
      pins_q  <= '0;
    end else if (acc) begin
      phase_q <= phase_d;
      wait_q  <= wait_d;
      byte_q  <= byte_d;
      rs_q    <= rs_d;
      idx_q   <= idx_d;
      low_q   <= low_d;
      pins_q  <= pins_d;
    end
  end

  // Output register: hold the result until the sink takes the transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (acc) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      out_o.rs       <= shown[5];
      out_o.en       <= shown[4];
      out_o.nibble   <= shown[3:0];
      out_o.busy_res <= (phase_d != PH_IDLE);
      out_o.rejected <= rej;
    end
  end

  assign out_o.valid = out_valid_q;

`include "char_lcd_4bit_sequencer_assert.svh"

  `CLCD_ASSERT_NEXT(a_reject_when_busy, acc && is_req && (phase_q != PH_IDLE), out_o.rejected)
  `CLCD_ASSERT_NOW(a_en_only_in_strobe, pins_q[4], phase_q == PH_EN)
  `CLCD_ASSERT_NOW(a_wait_live, phase_q != PH_IDLE, wait_q != '0)
  `CLCD_ASSERT_NOW(a_idle_no_wait, phase_q == PH_IDLE, wait_q == '0)

endmodule

`default_nettype wire

>>> hw/rtl/clcd_regs.sv
`default_nettype none

module clcd_regs (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [clcd_pkg::AddrW-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready,
  output clcd_pkg::cfg_t                  cfg_o
);

  clcd_pkg::cfg_t cfg_q;
  logic           wr_en;
  logic [2:0]     reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[clcd_pkg::AddrW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable_width      <= 16'd2;
      cfg_q.nibble_gap        <= 16'd100;
      cfg_q.command_gap       <= 16'd100;
      cfg_q.long_command_wait <= 17'd10000;
      cfg_q.powerup_wait      <= 17'd50000;
      cfg_q.init_step_wait    <= 17'd5000;
    end else if (wr_en) begin
      case (reg_idx)
        clcd_pkg::REG_ENABLE_WIDTH:   cfg_q.enable_width      <= pwdata[15:0];
        clcd_pkg::REG_NIBBLE_GAP:     cfg_q.nibble_gap        <= pwdata[15:0];
        clcd_pkg::REG_COMMAND_GAP:    cfg_q.command_gap       <= pwdata[15:0];
        clcd_pkg::REG_LONG_CMD_WAIT:  cfg_q.long_command_wait <= pwdata[16:0];
        clcd_pkg::REG_POWERUP_WAIT:   cfg_q.powerup_wait      <= pwdata[16:0];
        clcd_pkg::REG_INIT_STEP_WAIT: cfg_q.init_step_wait    <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      clcd_pkg::REG_ENABLE_WIDTH:   prdata = {16'h0, cfg_q.enable_width};
      clcd_pkg::REG_NIBBLE_GAP:     prdata = {16'h0, cfg_q.nibble_gap};
      clcd_pkg::REG_COMMAND_GAP:    prdata = {16'h0, cfg_q.command_gap};
      clcd_pkg::REG_LONG_CMD_WAIT:  prdata = {15'h0, cfg_q.long_command_wait};
      clcd_pkg::REG_POWERUP_WAIT:   prdata = {15'h0, cfg_q.powerup_wait};
      clcd_pkg::REG_INIT_STEP_WAIT: prdata = {15'h0, cfg_q.init_step_wait};
      default:                      prdata = 32'h0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire
